// ===== hdl/usd_pkg.sv =====
package usd_pkg;

    // Width of the internal invalid counter and of its visible low part.
    localparam int COUNT_WIDTH = 16;
    localparam int TOTAL_WIDTH = 16;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Replacement character and code point limits.
    localparam logic [20:0] REPL_CP     = 21'h00FFFD;
    localparam logic [20:0] MAX_CP      = 21'h10FFFF;
    localparam logic [20:0] MIN_FOUR_CP = 21'h010000;
    localparam logic [20:0] MIN_THREE_CP = 21'h000800;
    localparam logic [20:0] MIN_TWO_CP  = 21'h000080;
    localparam logic [20:0] SURR_LO     = 21'h00D800;
    localparam logic [20:0] SURR_HI     = 21'h00DFFF;

    // Lead and continuation byte patterns.
    localparam logic [7:0] MASK_C0 = 8'hC0;
    localparam logic [7:0] MASK_E0 = 8'hE0;
    localparam logic [7:0] MASK_F0 = 8'hF0;
    localparam logic [7:0] MASK_F8 = 8'hF8;
    localparam logic [7:0] PAT_CONT = 8'h80;
    localparam logic [7:0] PAT_LEAD2 = 8'hC0;
    localparam logic [7:0] PAT_LEAD3 = 8'hE0;
    localparam logic [7:0] PAT_LEAD4 = 8'hF0;

    // Sequence length codes, stored as length minus one.
    localparam logic [1:0] NEED_ONE   = 2'd0;
    localparam logic [1:0] NEED_TWO   = 2'd1;
    localparam logic [1:0] NEED_THREE = 2'd2;
    localparam logic [1:0] NEED_FOUR  = 2'd3;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_input;
    } item_t;

    typedef struct packed {
        logic [20:0]            code_point;
        logic                   is_invalid;
        logic                   run_last;
        logic                   stream_done;
        logic [TOTAL_WIDTH-1:0] invalid_total;
    } result_t;

    // A byte after classification: its value, the stream end mark, the
    // length of the sequence it would start and whether it continues one.
    typedef struct packed {
        logic [7:0] value;
        logic       eoi;
        logic [1:0] need_m1;
        logic       cont;
    } class_t;

    function automatic logic [1:0] seq_need_m1(input logic [7:0] b);
        logic [1:0] n;
        n = NEED_ONE;
        if (!b[7])
            n = NEED_ONE;
        else if ((b & MASK_E0) == PAT_LEAD2)
            n = NEED_TWO;
        else if ((b & MASK_F0) == PAT_LEAD3)
            n = NEED_THREE;
        else if ((b & MASK_F8) == PAT_LEAD4)
            n = NEED_FOUR;
        return n;
    endfunction

endpackage

// ===== hdl/usd_front.sv =====
module usd_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  usd_pkg::item_t item,
    output logic           head_valid,
    output usd_pkg::class_t head,
    input  logic           head_take
);
    import usd_pkg::*;

    // Two-entry queue of classified bytes feeding the decode engine.
    class_t     slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push, do_pop;
    class_t     classified;

    always_comb
    begin
        classified.value   = item.byte_value;
        classified.eoi     = item.end_of_input;
        classified.need_m1 = seq_need_m1(item.byte_value);
        classified.cont    = (item.byte_value & MASK_C0) == PAT_CONT;
    end

    assign full       = fill_reg == 2'd2;
    assign head_valid = fill_reg != 2'd0;
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = head_take && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + 2'd1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= classified;
    end

endmodule

// ===== hdl/usd_back.sv =====
module usd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  usd_pkg::class_t  head,
    output logic             head_take,
    output logic             res_push,
    output usd_pkg::result_t res,
    input  logic             res_space
);
    import usd_pkg::*;

    // Window of up to four bytes: held bytes of an open sequence plus the
    // newest byte. Consumed bytes are shifted out from the front.
    class_t                 win_reg [4];
    class_t                 win_next [4];
    logic [2:0]             wcnt_reg, wcnt_next;
    logic                   busy_reg, busy_next;
    logic                   last_reg, last_next;
    logic [COUNT_WIDTH-1:0] inv_reg, inv_next, inv_inc;

    class_t      b0, b1, b2, b3, nxt;
    logic        short_seq, hold, bad;
    logic [2:0]  need, used, rem, nxt_need;
    logic [20:0] cp, v2, v3, v4;
    logic        run_last;
    logic [2:0]  src;

    always_comb
    begin
        b0 = win_reg[0];
        b1 = win_reg[1];
        b2 = win_reg[2];
        b3 = win_reg[3];

        need      = {1'b0, b0.need_m1} + 3'd1;
        short_seq = need > wcnt_reg;
        hold      = short_seq && !last_reg;

        v2 = {10'd0, b0.value[4:0], b1.value[5:0]};
        v3 = {5'd0, b0.value[3:0], b1.value[5:0], b2.value[5:0]};
        v4 = {b0.value[2:0], b1.value[5:0], b2.value[5:0], b3.value[5:0]};

        cp   = REPL_CP;
        used = 3'd1;
        if (!short_seq)
        begin
            if (!b0.value[7])
                cp = {13'd0, b0.value};
            else
            begin
                case (b0.need_m1)
                    NEED_TWO:
                    begin
                        if (b1.cont && v2 >= MIN_TWO_CP)
                        begin
                            cp   = v2;
                            used = 3'd2;
                        end
                    end
                    NEED_THREE:
                    begin
                        if (b1.cont && b2.cont && v3 >= MIN_THREE_CP
                            && (v3 < SURR_LO || v3 > SURR_HI))
                        begin
                            cp   = v3;
                            used = 3'd3;
                        end
                    end
                    NEED_FOUR:
                    begin
                        if (b1.cont && b2.cont && b3.cont
                            && v4 >= MIN_FOUR_CP && v4 <= MAX_CP)
                        begin
                            cp   = v4;
                            used = 3'd4;
                        end
                    end
                    default:
                    begin
                        cp   = REPL_CP;
                        used = 3'd1;
                    end
                endcase
            end
        end

        bad     = (cp == REPL_CP) && b0.value[7];
        inv_inc = (bad && inv_reg != COUNT_MAX) ? inv_reg + 1'b1 : inv_reg;

        // The step ends on this result when nothing is left, or when the
        // next head cannot complete yet and the stream goes on.
        rem      = wcnt_reg - used;
        nxt      = win_reg[used[1:0]];
        nxt_need = {1'b0, nxt.need_m1} + 3'd1;
        run_last = (rem == 3'd0) || (!last_reg && nxt_need > rem);

        res.code_point    = cp;
        res.is_invalid    = bad;
        res.run_last      = run_last;
        res.stream_done   = last_reg && (rem == 3'd0);
        res.invalid_total = TOTAL_WIDTH'(inv_inc);

        head_take = !busy_reg && head_valid;
        res_push  = busy_reg && !hold && res_space;

        for (int i = 0; i < 4; i++)
            win_next[i] = win_reg[i];
        wcnt_next = wcnt_reg;
        busy_next = busy_reg;
        last_next = last_reg;
        inv_next  = inv_reg;
        src       = 3'd0;

        if (head_take)
        begin
            win_next[wcnt_reg[1:0]] = head;
            wcnt_next = wcnt_reg + 3'd1;
            busy_next = 1'b1;
            last_next = head.eoi;
        end
        else if (busy_reg && hold)
        begin
            busy_next = 1'b0;
        end
        else if (res_push)
        begin
            for (int i = 0; i < 4; i++)
            begin
                src = 3'(i) + used;
                if (src < 3'd4)
                    win_next[i] = win_reg[src[1:0]];
            end
            wcnt_next = rem;
            inv_next  = inv_inc;
            if (run_last)
            begin
                busy_next = 1'b0;
                if (last_reg)
                    inv_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wcnt_reg <= 3'd0;
            busy_reg <= 1'b0;
            last_reg <= 1'b0;
            inv_reg  <= '0;
        end
        else
        begin
            wcnt_reg <= wcnt_next;
            busy_reg <= busy_next;
            last_reg <= last_next;
            inv_reg  <= inv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
            win_reg[i] <= win_next[i];
    end

endmodule

// ===== hdl/usd_result_queue.sv =====
module usd_result_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  usd_pkg::result_t wr_data,
    output logic             space,
    output logic             empty,
    input  logic             pop,
    output usd_pkg::result_t result
);
    import usd_pkg::*;

    result_t    slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push, do_pop;

    assign space   = fill_reg != 2'd2;
    assign empty   = fill_reg == 2'd0;
    assign result  = slot_reg[rd_ptr_reg];
    assign do_push = wr_en && space;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + 2'd1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== hdl/utf8_stream_decoder.sv =====
// A byte that completes a sequence is first loaded into the window, then decoded into the
// result queue. The decode engine takes no new byte while it is busy: it first releases each
// result the window can give, or finds the head sequence still open, and only then takes the
// next byte; a full result queue stalls the decode engine until a word is popped.
// Reset (rst_n, asynchronous, active low) empties both queues, held bytes and the invalid count.
module utf8_stream_decoder (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  usd_pkg::item_t   item,
    output logic             empty,
    input  logic             pop,
    output usd_pkg::result_t result
);
    import usd_pkg::*;

    // The front part takes each word, tags it with the length of the
    // sequence it would lead and whether it is a continuation byte, and
    // queues it. The back part owns the four-byte window: it appends one
    // queued byte, then resolves sequences from the window head one result
    // per cycle while the result queue has room until the window is empty
    // or the head needs more bytes. A failed sequence gives U+FFFD and
    // consumes only its lead; next bytes are examined again as new starts.
    class_t  head;
    logic    head_valid;
    logic    head_take;
    result_t res;
    logic    res_push;
    logic    res_space;

    usd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .head_valid (head_valid),
        .head       (head),
        .head_take  (head_take)
    );

    // The decode engine stalls on its own when the result queue is full,
    // while the front queue keeps taking words until it fills.
    usd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .head_take  (head_take),
        .res_push   (res_push),
        .res        (res),
        .res_space  (res_space)
    );

    // Result words wait here until popped; the oldest is shown while
    // empty is low.
    usd_result_queue u_result_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res),
        .space   (res_space),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
